>>> hw/rtl/xxh_pkg.sv
`timescale 1ns / 1ps

package xxh_pkg;

    localparam logic [63:0] K_P1 = 64'd11400714785074694791;
    localparam logic [63:0] K_P2 = 64'd14029467366897019727;
    localparam logic [63:0] K_P3 = 64'd1609587929392839161;
    localparam logic [63:0] K_P4 = 64'd9650029242287828579;
    localparam logic [63:0] K_P5 = 64'd2870177450012600261;

    // lane start values for seed zero
    localparam logic [63:0] K_LANE0 = K_P1 + K_P2;
    localparam logic [63:0] K_LANE1 = K_P2;
    localparam logic [63:0] K_LANE2 = 64'd0;
    localparam logic [63:0] K_LANE3 = 64'd0 - K_P1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH,
        ST_F_LD, ST_F_LR, ST_F_WR,
        ST_START,
        ST_M_LD, ST_M_LR, ST_M_XH, ST_M_WR,
        ST_LEN,
        ST_W_CHK, ST_W_LD, ST_W_LR, ST_W_XH, ST_W_WR,
        ST_H_CHK, ST_H_XH, ST_H_WR,
        ST_B_CHK, ST_B_XH, ST_B_WR,
        ST_AV1, ST_AV2, ST_AV3,
        ST_MUL0, ST_MUL1, ST_MUL2
    } t_state;

    typedef enum logic [3:0] {
        XS_PEND, XS_TAILW, XS_LANE, XS_WLO, XS_BYTE, XS_LR,
        XS_HP, XS_HP27, XS_HP23, XS_HP11, XS_AV1, XS_AV2
    } t_xsrc;

    typedef enum logic [1:0] {
        KS_P1, KS_P2, KS_P3, KS_P5
    } t_ksel;

    typedef enum logic [1:0] {
        MS_NONE, MS_LL, MS_LH, MS_HL
    } t_mstep;

    typedef enum logic [2:0] {
        HS_KEEP, HS_MERGE, HS_P5, HS_ADDLEN, HS_PP4, HS_PP3, HS_P
    } t_hsel;

    typedef struct packed {
        logic       capture;
        logic       pend_push;
        logic       x_we;
        t_xsrc      xsrc;
        t_ksel      ksel;
        t_mstep     mstep;
        logic       lr_acc;
        logic       lane_we;
        logic       fold_done;
        t_hsel      hsel;
        logic [1:0] idx;
        logic [2:0] bidx;
        logic       out_load;
        logic       clear;
    } t_cmd;

    typedef struct packed {
        logic       last;
        logic [3:0] cnt;
        logic [1:0] pcnt;
        logic       stripes;
        logic       out_free;
    } t_status;

    function automatic logic [63:0] f_rotl(input logic [63:0] x, input int r);
        f_rotl = (x << r) | (x >> (64 - r));
    endfunction

endpackage

>>> hw/rtl/xxh64_stream_hash.sv
`timescale 1ns / 1ps

// XXH64 stream hash, seed zero. Feed the message as little-endian 64-bit
// beats, byte 0 in bits 7..0; every beat but the last is taken as 8 bytes,
// and the beat with i_last high carries 0..8 bytes (counts above 8 act as 8)
// and closes the message. One o_hash beat follows each last beat, after
// which the lanes, pending count, length and stripe flag are back at their
// start values. Every multiply runs through a single 32x32 multiplier; each
// 64-bit product takes three passes after its operand load. A word that
// only joins the pending buffer is just stored there; a word that completes
// a 32-byte stripe runs four lane rounds. The last beat adds a tail: the
// stripe fold if it completes a stripe, the lane merge if 32 bytes or more
// were seen, the length add, one round per leftover word, a half-word round
// if 4 to 7 bytes are left, one round per leftover byte and the avalanche;
// the final step waits while an earlier hash still sits stalled in the
// output register.
// The input stalls during all of this; a finished hash sits in the output
// register while the next message starts streaming in.

module xxh64_stream_hash
    import xxh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_hash
);

    t_cmd    w_cmd;
    t_status w_st;
    logic    w_ready;

    // controller sequences lane rounds, merge, tail rules and avalanche
    xxh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_st    (w_st),
        .o_ready (w_ready),
        .o_cmd   (w_cmd)
    );

    // datapath holds lanes, pending words, length, hash and output beat
    xxh_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .i_stall      (i_stall),
        .o_st         (w_st),
        .o_valid      (o_valid),
        .o_hash       (o_hash)
    );

    // hold the input side whenever the controller is busy
    assign o_stall = !w_ready;

endmodule

>>> hw/rtl/xxh_ctrl.sv
`timescale 1ns / 1ps

module xxh_ctrl
    import xxh_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_status i_st,
    output logic    o_ready,
    output t_cmd    o_cmd
);

    t_state     r_state, n_state;
    t_state     r_ret, n_ret;
    logic [1:0] r_idx, n_idx;
    logic [3:0] r_b, n_b;
    logic [1:0] v_ntot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_idx   <= 2'd0;
            r_b     <= 4'd0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_idx   <= n_idx;
            r_b     <= n_b;
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    // words left for the tail: pending ones plus a full last word
    assign v_ntot  = i_st.pcnt + {1'b0, (i_st.cnt == 4'd8)};

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_idx   = r_idx;
        n_b     = r_b;
        o_cmd   = '0;
        o_cmd.xsrc  = XS_PEND;
        o_cmd.ksel  = KS_P1;
        o_cmd.mstep = MS_NONE;
        o_cmd.hsel  = HS_KEEP;
        o_cmd.idx   = r_idx;
        o_cmd.bidx  = r_b[2:0];
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_idx = 2'd0;
                if (!i_st.last) begin
                    if (i_st.pcnt != 2'd3) begin
                        o_cmd.pend_push = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_F_LD;
                    end
                end else if (i_st.cnt == 4'd8 && i_st.pcnt == 2'd3) begin
                    n_state = ST_F_LD;
                end else begin
                    n_state = ST_START;
                end
            end
            ST_F_LD: begin
                o_cmd.x_we = 1'b1;
                o_cmd.xsrc = XS_PEND;
                o_cmd.ksel = KS_P2;
                n_ret   = ST_F_LR;
                n_state = ST_MUL0;
            end
            ST_F_LR: begin
                o_cmd.x_we   = 1'b1;
                o_cmd.xsrc   = XS_LR;
                o_cmd.lr_acc = 1'b1;
                o_cmd.ksel   = KS_P1;
                n_ret   = ST_F_WR;
                n_state = ST_MUL0;
            end
            ST_F_WR: begin
                o_cmd.lane_we = 1'b1;
                n_idx = r_idx + 2'd1;
                if (r_idx == 2'd3) begin
                    o_cmd.fold_done = 1'b1;
                    n_state = i_st.last ? ST_START : ST_IDLE;
                end else begin
                    n_state = ST_F_LD;
                end
            end
            ST_START: begin
                n_idx = 2'd0;
                if (i_st.stripes) begin
                    o_cmd.hsel = HS_MERGE;
                    n_state = ST_M_LD;
                end else begin
                    o_cmd.hsel = HS_P5;
                    n_state = ST_LEN;
                end
            end
            ST_M_LD: begin
                o_cmd.x_we = 1'b1;
                o_cmd.xsrc = XS_LANE;
                o_cmd.ksel = KS_P2;
                n_ret   = ST_M_LR;
                n_state = ST_MUL0;
            end
            ST_M_LR: begin
                o_cmd.x_we = 1'b1;
                o_cmd.xsrc = XS_LR;
                o_cmd.ksel = KS_P1;
                n_ret   = ST_M_XH;
                n_state = ST_MUL0;
            end
            ST_M_XH: begin
                o_cmd.x_we = 1'b1;
                o_cmd.xsrc = XS_HP;
                o_cmd.ksel = KS_P1;
                n_ret   = ST_M_WR;
                n_state = ST_MUL0;
            end
            ST_M_WR: begin
                o_cmd.hsel = HS_PP4;
                n_idx = r_idx + 2'd1;
                n_state = (r_idx == 2'd3) ? ST_LEN : ST_M_LD;
            end
            ST_LEN: begin
                o_cmd.hsel = HS_ADDLEN;
                n_idx   = 2'd0;
                n_state = ST_W_CHK;
            end
            ST_W_CHK: begin
                n_state = (r_idx < v_ntot) ? ST_W_LD : ST_H_CHK;
            end
            ST_W_LD: begin
                o_cmd.x_we = 1'b1;
                o_cmd.xsrc = XS_TAILW;
                o_cmd.ksel = KS_P2;
                n_ret   = ST_W_LR;
                n_state = ST_MUL0;
            end
            ST_W_LR: begin
                o_cmd.x_we = 1'b1;
                o_cmd.xsrc = XS_LR;
                o_cmd.ksel = KS_P1;
                n_ret   = ST_W_XH;
                n_state = ST_MUL0;
            end
            ST_W_XH: begin
                o_cmd.x_we = 1'b1;
                o_cmd.xsrc = XS_HP27;
                o_cmd.ksel = KS_P1;
                n_ret   = ST_W_WR;
                n_state = ST_MUL0;
            end
            ST_W_WR: begin
                o_cmd.hsel = HS_PP4;
                n_idx   = r_idx + 2'd1;
                n_state = ST_W_CHK;
            end
            ST_H_CHK: begin
                if (i_st.cnt == 4'd8) begin
                    n_b     = 4'd8;
                    n_state = ST_B_CHK;
                end else if (i_st.cnt >= 4'd4) begin
                    o_cmd.x_we = 1'b1;
                    o_cmd.xsrc = XS_WLO;
                    o_cmd.ksel = KS_P1;
                    n_b     = 4'd4;
                    n_ret   = ST_H_XH;
                    n_state = ST_MUL0;
                end else begin
                    n_b     = 4'd0;
                    n_state = ST_B_CHK;
                end
            end
            ST_H_XH: begin
                o_cmd.x_we = 1'b1;
                o_cmd.xsrc = XS_HP23;
                o_cmd.ksel = KS_P2;
                n_ret   = ST_H_WR;
                n_state = ST_MUL0;
            end
            ST_H_WR: begin
                o_cmd.hsel = HS_PP3;
                n_state = ST_B_CHK;
            end
            ST_B_CHK: begin
                if (r_b < i_st.cnt) begin
                    o_cmd.x_we = 1'b1;
                    o_cmd.xsrc = XS_BYTE;
                    o_cmd.ksel = KS_P5;
                    n_ret   = ST_B_XH;
                    n_state = ST_MUL0;
                end else begin
                    n_state = ST_AV1;
                end
            end
            ST_B_XH: begin
                o_cmd.x_we = 1'b1;
                o_cmd.xsrc = XS_HP11;
                o_cmd.ksel = KS_P1;
                n_ret   = ST_B_WR;
                n_state = ST_MUL0;
            end
            ST_B_WR: begin
                o_cmd.hsel = HS_P;
                n_b     = r_b + 4'd1;
                n_state = ST_B_CHK;
            end
            ST_AV1: begin
                o_cmd.x_we = 1'b1;
                o_cmd.xsrc = XS_AV1;
                o_cmd.ksel = KS_P2;
                n_ret   = ST_AV2;
                n_state = ST_MUL0;
            end
            ST_AV2: begin
                o_cmd.x_we = 1'b1;
                o_cmd.xsrc = XS_AV2;
                o_cmd.ksel = KS_P3;
                n_ret   = ST_AV3;
                n_state = ST_MUL0;
            end
            ST_AV3: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.clear    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_MUL0: begin
                o_cmd.mstep = MS_LL;
                n_state = ST_MUL1;
            end
            ST_MUL1: begin
                o_cmd.mstep = MS_LH;
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mstep = MS_HL;
                n_state = r_ret;
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

>>> hw/rtl/xxh_dp.sv
`timescale 1ns / 1ps

module xxh_dp
    import xxh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last,
    input  logic        i_stall,
    output t_status     o_st,
    output logic        o_valid,
    output logic [63:0] o_hash
);

    logic [63:0] r_lane [4];
    logic [63:0] r_pend [3];
    logic [1:0]  r_pcnt;
    logic [63:0] r_len;
    logic        r_stripes;
    logic [63:0] r_word;
    logic [3:0]  r_cnt;
    logic        r_last;
    logic [63:0] r_x;
    logic [63:0] r_k;
    logic [63:0] r_p;
    logic [63:0] r_h;
    logic [63:0] r_hash;
    logic        r_out_valid;

    logic [3:0]  v_cnt;
    logic [63:0] v_pend;
    logic [63:0] v_xin;
    logic [63:0] v_kin;
    logic [63:0] v_hp;
    logic [63:0] v_base;
    logic [31:0] v_ma, v_mb;
    logic [63:0] v_prod;

    // effective byte count: eight unless last, clamped to eight
    assign v_cnt = !i_last ? 4'd8 : ((i_byte_count > 4'd8) ? 4'd8 : i_byte_count);

    always_comb begin
        case (i_cmd.idx)
            2'd0:    v_pend = r_pend[0];
            2'd1:    v_pend = r_pend[1];
            2'd2:    v_pend = r_pend[2];
            default: v_pend = r_word;
        endcase
    end

    assign v_hp   = r_h ^ r_p;
    assign v_base = i_cmd.lr_acc ? r_lane[i_cmd.idx] : 64'd0;

    always_comb begin
        case (i_cmd.xsrc)
            XS_PEND:  v_xin = v_pend;
            XS_TAILW: v_xin = (i_cmd.idx == r_pcnt) ? r_word : v_pend;
            XS_LANE:  v_xin = r_lane[i_cmd.idx];
            XS_WLO:   v_xin = {32'd0, r_word[31:0]};
            XS_BYTE:  v_xin = {56'd0, 8'(r_word >> {i_cmd.bidx, 3'b000})};
            XS_LR:    v_xin = f_rotl(v_base + r_p, 31);
            XS_HP:    v_xin = v_hp;
            XS_HP27:  v_xin = f_rotl(v_hp, 27);
            XS_HP23:  v_xin = f_rotl(v_hp, 23);
            XS_HP11:  v_xin = f_rotl(v_hp, 11);
            XS_AV1:   v_xin = r_h ^ (r_h >> 33);
            XS_AV2:   v_xin = r_p ^ (r_p >> 29);
            default:  v_xin = r_word;
        endcase
    end

    always_comb begin
        case (i_cmd.ksel)
            KS_P1:   v_kin = K_P1;
            KS_P2:   v_kin = K_P2;
            KS_P3:   v_kin = K_P3;
            default: v_kin = K_P5;
        endcase
    end

    // one 32x32 multiplier, three passes for the low 64 bits of the product
    assign v_ma   = (i_cmd.mstep == MS_HL) ? r_x[63:32] : r_x[31:0];
    assign v_mb   = (i_cmd.mstep == MS_LH) ? r_k[63:32] : r_k[31:0];
    assign v_prod = v_ma * v_mb;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_word <= i_data_word;
            r_cnt  <= v_cnt;
            r_last <= i_last;
        end else if (i_cmd.fold_done && r_last) begin
            r_cnt <= 4'd0;
        end
        if (i_cmd.pend_push) begin
            r_pend[r_pcnt] <= r_word;
        end
        if (i_cmd.x_we) begin
            r_x <= v_xin;
            r_k <= v_kin;
        end
        case (i_cmd.mstep)
            MS_LL:   r_p <= v_prod;
            MS_LH,
            MS_HL:   r_p <= r_p + {v_prod[31:0], 32'd0};
            default: r_p <= r_p;
        endcase
        case (i_cmd.hsel)
            HS_MERGE:  r_h <= f_rotl(r_lane[0], 1) + f_rotl(r_lane[1], 7)
                            + f_rotl(r_lane[2], 12) + f_rotl(r_lane[3], 18);
            HS_P5:     r_h <= K_P5;
            HS_ADDLEN: r_h <= r_h + r_len;
            HS_PP4:    r_h <= r_p + K_P4;
            HS_PP3:    r_h <= r_p + K_P3;
            HS_P:      r_h <= r_p;
            default:   r_h <= r_h;
        endcase
        if (i_cmd.out_load) begin
            r_hash <= r_p ^ (r_p >> 32);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_lane[0] <= K_LANE0;
            r_lane[1] <= K_LANE1;
            r_lane[2] <= K_LANE2;
            r_lane[3] <= K_LANE3;
            r_pcnt    <= 2'd0;
            r_len     <= 64'd0;
            r_stripes <= 1'b0;
        end else begin
            if (i_cmd.lane_we) begin
                r_lane[i_cmd.idx] <= r_p;
            end
            if (i_cmd.capture) begin
                r_len <= r_len + {60'd0, v_cnt};
            end
            if (i_cmd.pend_push) begin
                r_pcnt <= r_pcnt + 2'd1;
            end else if (i_cmd.fold_done) begin
                r_pcnt    <= 2'd0;
                r_stripes <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_st.last     = r_last;
    assign o_st.cnt      = r_cnt;
    assign o_st.pcnt     = r_pcnt;
    assign o_st.stripes  = r_stripes;
    assign o_st.out_free = !r_out_valid || !i_stall;
    assign o_valid       = r_out_valid;
    assign o_hash        = r_hash;

endmodule

>>> tb/sv/xxh64_stream_hash_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the XXH64 stream hasher. The bench predicts each
// digest as beats are accepted and compares every o_hash beat against the
// oldest pending digest.
module xxh64_stream_hash_tb;
    import xxh_pkg::*;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  cnt;
        logic        last;
    } t_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_data_word;
    logic [3:0]  i_byte_count;
    logic        i_last;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_hash;

    xxh64_stream_hash i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hash       (o_hash)
    );

    t_beat       beat_q[$];
    logic [63:0] digest_q[$];
    int          n_mismatch;
    int          n_beats;
    int          n_digests;
    int          n_msgs;
    bit          stim_done;
    bit          calm;

    // Predictor state, mirrors the hasher's lanes and buffers.
    logic [63:0] lane[4];
    logic [63:0] pend[3];
    int          pend_n;
    logic [63:0] msg_len;
    bit          folded;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
        return (r == 0) ? x : ((x << r) | (x >> (64 - r)));
    endfunction

    function automatic logic [63:0] lane_rnd(input logic [63:0] acc,
                                             input logic [63:0] w);
        acc = acc + w * K_P2;
        return rotl(acc, 31) * K_P1;
    endfunction

    task automatic hash_clear();
        lane[0] = K_LANE0;
        lane[1] = K_LANE1;
        lane[2] = K_LANE2;
        lane[3] = K_LANE3;
        pend_n  = 0;
        msg_len = 64'd0;
        folded  = 1'b0;
    endtask

    task automatic fold(input logic [63:0] w3);
        lane[0] = lane_rnd(lane[0], pend[0]);
        lane[1] = lane_rnd(lane[1], pend[1]);
        lane[2] = lane_rnd(lane[2], pend[2]);
        lane[3] = lane_rnd(lane[3], w3);
        pend_n  = 0;
        folded  = 1'b1;
    endtask

    // Advance the predictor by one accepted beat; queue a digest on last.
    task automatic hash_absorb(input t_beat b);
        logic [63:0] h;
        int          c;
        int          k;
        if (!b.last) begin
            msg_len += 64'd8;
            if (pend_n < 3) begin
                pend[pend_n] = b.word;
                pend_n++;
            end else begin
                fold(b.word);
            end
            return;
        end
        c = (b.cnt > 4'd8) ? 8 : int'(b.cnt);
        msg_len += 64'(c);
        if (c == 8 && pend_n == 3) begin
            fold(b.word);
            c = 0;
        end
        if (folded) begin
            h = rotl(lane[0], 1) + rotl(lane[1], 7) + rotl(lane[2], 12) + rotl(lane[3], 18);
            for (k = 0; k < 4; k++) begin
                h ^= lane_rnd(64'd0, lane[k]);
                h = h * K_P1 + K_P4;
            end
        end else begin
            h = K_P5;
        end
        h += msg_len;
        for (k = 0; k < pend_n; k++) begin
            h ^= lane_rnd(64'd0, pend[k]);
            h = rotl(h, 27) * K_P1 + K_P4;
        end
        k = 0;
        if (c == 8) begin
            h ^= lane_rnd(64'd0, b.word);
            h = rotl(h, 27) * K_P1 + K_P4;
            k = 8;
        end else if (c >= 4) begin
            h ^= {32'd0, b.word[31:0]} * K_P1;
            h = rotl(h, 23) * K_P2 + K_P3;
            k = 4;
        end
        for (; k < c; k++) begin
            h ^= {56'd0, b.word[8*k +: 8]} * K_P5;
            h = rotl(h, 11) * K_P1;
        end
        h ^= h >> 33;
        h *= K_P2;
        h ^= h >> 29;
        h *= K_P3;
        h ^= h >> 32;
        digest_q.insert(digest_q.size(), h);
        hash_clear();
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // Queue one message of nfull 8-byte beats and a last beat of tail bytes.
    // Non-last beats get a random count to show it is ignored.
    task automatic add_msg(input int nfull, input logic [3:0] tail,
                           input bit fill_ones);
        t_beat b;
        for (int k = 0; k <= nfull; k++) begin
            b.word = fill_ones ? '1 : rnd64();
            b.last = (k == nfull);
            b.cnt  = b.last ? tail : 4'($urandom_range(0, 15));
            beat_q.insert(beat_q.size(), b);
        end
        n_msgs++;
    endtask

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    // Stimulus: directed corner messages first, then random lengths.
    initial begin
        int total;
        hash_clear();
        n_msgs = 0;
        add_msg(0, 4'd0, 1'b0);     // empty message
        add_msg(0, 4'd8, 1'b1);     // one full word, all ones
        add_msg(0, 4'd15, 1'b0);    // count above eight
        add_msg(0, 4'd4, 1'b0);     // half word only
        add_msg(0, 4'd7, 1'b1);     // half word plus bytes
        add_msg(2, 4'd3, 1'b0);     // pending words plus bytes
        add_msg(3, 4'd8, 1'b0);     // last beat completes a stripe
        add_msg(4, 4'd0, 1'b1);     // one stripe, nothing left
        add_msg(3, 4'd9, 1'b0);     // stripe closed by an oversized count
        total = beat_q.size();
        while (total < 950) begin
            int nf;
            nf = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24)
                                              : $urandom_range(0, 7);
            add_msg(nf, 4'($urandom_range(0, 15)), 1'b0);
            total += nf + 1;
        end
    end

    // Reset and end of run.
    initial begin
        int guard;
        i_rst_n = 0;
        calm = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        wait (n_beats > 800);
        calm = 1;
        wait (stim_done);
        guard = 0;
        while (digest_q.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (300) @(posedge i_clk);
        $display("covered %0d beats in %0d messages, %0d digests checked",
                 n_beats, n_msgs, n_digests);
        if (n_mismatch == 0 && digest_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches, %0d digests missing", n_mismatch, digest_q.size());
            $display("TB_ERROR");
        end
        $finish;
    end

    // Driver: present beats from the queue, with random idle bursts.
    int idle_in;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid      <= 0;
            i_data_word  <= '0;
            i_byte_count <= '0;
            i_last       <= 0;
            idle_in      <= 0;
            stim_done    <= 0;
            n_beats      <= 0;
        end else begin
            logic taken;
            taken = i_valid && !o_stall;
            if (taken) begin
                hash_absorb(beat_q.pop_front());
                n_beats <= n_beats + 1;
            end
            if (i_valid && !taken) begin
                // hold the stalled beat
            end else if (idle_in > 0) begin
                i_valid <= 0;
                idle_in <= idle_in - 1;
            end else if (!calm && taken && $urandom_range(0, 5) == 0) begin
                i_valid <= 0;
                idle_in <= $urandom_range(0, 13);
            end else if (beat_q.size() > 0) begin
                i_valid      <= 1;
                i_data_word  <= beat_q[0].word;
                i_byte_count <= beat_q[0].cnt;
                i_last       <= beat_q[0].last;
            end else begin
                i_valid   <= 0;
                stim_done <= 1;
            end
        end
    end

    // Monitor: random stall bursts on the output, check each digest beat.
    int idle_out;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 0;
            idle_out   <= 0;
            n_mismatch <= 0;
            n_digests  <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                n_digests <= n_digests + 1;
                if (digest_q.size() == 0) begin
                    if (n_mismatch < 10)
                        $display("unexpected digest %h", o_hash);
                    n_mismatch <= n_mismatch + 1;
                end else begin
                    logic [63:0] want;
                    want = digest_q.pop_front();
                    if (o_hash !== want) begin
                        if (n_mismatch < 10)
                            $display("digest mismatch: expected %h got %h", want, o_hash);
                        n_mismatch <= n_mismatch + 1;
                    end
                end
            end
            if (idle_out > 0) begin
                i_stall  <= 1;
                idle_out <= idle_out - 1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_stall  <= 1;
                idle_out <= $urandom_range(0, 13);
            end else begin
                i_stall <= 0;
            end
        end
    end
endmodule
